FILE: src/drf_pkg.sv
// shared types, byte codes and the crc-16 step function for the record framer
package drf_pkg;

	localparam logic [7:0]  BYTE_DLE = 8'h10;
	localparam logic [7:0]  BYTE_CR  = 8'h0D;
	localparam logic [7:0]  BYTE_LF  = 8'h0A;
	localparam logic [7:0]  PRINT_LO = 8'h20;
	localparam logic [7:0]  PRINT_HI = 8'h7E;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// configuration register indexes
	localparam logic [1:0] REG_START_CODE  = 2'd0;
	localparam logic [1:0] REG_END_CODE    = 2'd1;
	localparam logic [1:0] REG_APPEND_CRLF = 2'd2;
	localparam logic [1:0] REG_REC_CRC_EN  = 2'd3;

	// input command codes
	localparam logic CMD_SEND  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// one message byte handed from the front to the back
	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [15:0] rec_crc;
	} job_t;

	// reflected crc-16, one byte, lsb first
	function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		logic [7:0]  v;
		c = crc;
		v = b;
		for (int k = 0; k < 8; k++) begin
			if ((v[0] ^ c[0]) == 1'b1) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			v = v >> 1;
		end
		return c;
	endfunction

endpackage

FILE: src/drf_front.sv
// front end: takes input words, keeps the running record crc and record position
module drf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          cmd,
	input  logic [7:0]    data_byte,
	input  logic          last,
	input  logic          is_retry,
	input  logic          rec_crc_en,
	input  logic          q_full,
	output logic          q_push,
	output drf_pkg::job_t q_job
);

	logic        inside_q;
	logic [15:0] run_crc_q;
	logic        accept;
	logic        printable;
	logic [15:0] run_crc_d;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign printable = (data_byte >= drf_pkg::PRINT_LO) && (data_byte <= drf_pkg::PRINT_HI);

	always_comb begin
		run_crc_d = run_crc_q;
		if (cmd == drf_pkg::CMD_CLEAR) begin
			run_crc_d = '0;
		end else if (rec_crc_en && !is_retry && printable) begin
			run_crc_d = drf_pkg::crc_byte(run_crc_q, data_byte);
		end
	end

	assign q_push        = accept && (cmd == drf_pkg::CMD_SEND);
	assign q_job.data    = data_byte;
	assign q_job.first   = !inside_q;
	assign q_job.last    = last;
	assign q_job.rec_crc = run_crc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q  <= 1'b0;
			run_crc_q <= '0;
		end else if (accept) begin
			run_crc_q <= run_crc_d;
			if (cmd == drf_pkg::CMD_SEND) begin
				inside_q <= !last;
			end
		end
	end

endmodule

FILE: src/drf_fifo.sv
// short queue of message bytes between front and back
module drf_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  drf_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output drf_pkg::job_t dout
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	drf_pkg::job_t   slot_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == FULL_CNT);
	assign valid = (cnt_q != '0);
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/drf_back.sv
// back end: expands each queued byte into frame bytes and keeps the block crc
module drf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  drf_pkg::job_t job,
	output logic          pop,
	input  logic [7:0]    start_code,
	input  logic [7:0]    end_code,
	input  logic          append_crlf,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          run_last,
	output logic          frame_end,
	output logic [15:0]   rec_check
);

	typedef enum logic [3:0] {
		PH_DLE_HEAD,
		PH_START,
		PH_DATA,
		PH_CR,
		PH_LF,
		PH_DLE_TAIL,
		PH_END,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	phase_t      ph_q;
	logic        busy_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        run_last_q;
	logic        fend_q;
	logic [15:0] rec_crc_q;
	logic [15:0] blk_q;

	phase_t      cur_ph;
	phase_t      nxt_ph;
	logic [7:0]  byte_d;
	logic        done;
	logic        fend_d;
	logic        blk_clr;
	logic        blk_upd;
	logic        can_load;
	logic        load;
	logic [15:0] blk_next;

	assign cur_ph = busy_q ? ph_q : (job.first ? PH_DLE_HEAD : PH_DATA);

	always_comb begin
		byte_d  = job.data;
		nxt_ph  = cur_ph;
		done    = 1'b0;
		fend_d  = 1'b0;
		blk_clr = 1'b0;
		blk_upd = 1'b0;
		unique case (cur_ph)
			PH_DLE_HEAD: begin
				byte_d  = drf_pkg::BYTE_DLE;
				nxt_ph  = PH_START;
				blk_clr = 1'b1;
			end
			PH_START: begin
				byte_d = start_code;
				nxt_ph = PH_DATA;
			end
			PH_DATA: begin
				byte_d  = job.data;
				blk_upd = 1'b1;
				done    = !job.last;
				nxt_ph  = append_crlf ? PH_CR : PH_DLE_TAIL;
			end
			PH_CR: begin
				byte_d  = drf_pkg::BYTE_CR;
				blk_upd = 1'b1;
				nxt_ph  = PH_LF;
			end
			PH_LF: begin
				byte_d  = drf_pkg::BYTE_LF;
				blk_upd = 1'b1;
				nxt_ph  = PH_DLE_TAIL;
			end
			PH_DLE_TAIL: begin
				byte_d = drf_pkg::BYTE_DLE;
				nxt_ph = PH_END;
			end
			PH_END: begin
				byte_d  = end_code;
				blk_upd = 1'b1;
				nxt_ph  = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				byte_d = blk_q[7:0];
				nxt_ph = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				byte_d = blk_q[15:8];
				fend_d = 1'b1;
				done   = 1'b1;
			end
			default: begin
				byte_d = job.data;
			end
		endcase
	end

	// the crc input is the byte being sent on every phase that updates it
	assign blk_next = drf_pkg::crc_byte(blk_q, byte_d);

	assign can_load = !out_valid_q || out_ready;
	assign load     = can_load && job_valid;
	assign pop      = load && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_DLE_HEAD;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			byte_q      <= '0;
			run_last_q  <= 1'b0;
			fend_q      <= 1'b0;
			rec_crc_q   <= '0;
			blk_q       <= '0;
		end else begin
			if (can_load) begin
				out_valid_q <= job_valid;
			end
			if (load) begin
				byte_q     <= byte_d;
				run_last_q <= done;
				fend_q     <= fend_d;
				rec_crc_q  <= job.rec_crc;
				busy_q     <= !done;
				ph_q       <= nxt_ph;
				if (blk_clr) begin
					blk_q <= '0;
				end else if (blk_upd) begin
					blk_q <= blk_next;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = byte_q;
	assign run_last   = run_last_q;
	assign frame_end  = fend_q;
	assign rec_check  = rec_crc_q;

endmodule

FILE: src/dex_record_framer_crc16.sv
// record framer top level: frames message bytes with dle codes and a crc-16 trailer
//
// input stream: one message byte per word; tlast marks the final byte of a
// record, tuser carries the clear command and the retry flag. a clear word
// zeroes the running record crc and sends nothing. output stream: one framed
// byte per word, with the running record crc beside it; tlast marks the
// final byte caused by an input word, tuser marks the high crc byte that
// closes the frame.
// an accepted word passes through the queue into the output register. the
// back end sends one byte per cycle while m_tready does not stall it: a
// mid-record byte gives one frame byte, a record's first byte gives dle,
// start code and data, its last gives data, cr lf if on, dle, end code and
// both crc bytes. a short queue sits between the input and output sides, so
// input keeps flowing while the receiver stalls until the queue fills, then
// s_tready drops. a stalled output word holds.
// reset clears the record position, both crcs and the queue, and loads
// the code registers with start 0x01, end 0x03, cr lf and record crc off.
// configuration is written through cfg_we, cfg_index and cfg_data.
module dex_record_framer_crc16 #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	input  logic [1:0]  s_tuser,   // [0] cmd, [1] is_retry
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] running record crc
	output logic        m_tlast,
	output logic [0:0]  m_tuser,   // [0] frame_end
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] start_code_q;
	logic [7:0] end_code_q;
	logic       append_crlf_q;
	logic       rec_crc_en_q;

	drf_pkg::job_t push_job;
	drf_pkg::job_t head_job;
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	logic [7:0]    out_byte;
	logic [15:0]   rec_check;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q  <= 8'h01;
			end_code_q    <= 8'h03;
			append_crlf_q <= 1'b0;
			rec_crc_en_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				drf_pkg::REG_START_CODE:  start_code_q  <= cfg_data;
				drf_pkg::REG_END_CODE:    end_code_q    <= cfg_data;
				drf_pkg::REG_APPEND_CRLF: append_crlf_q <= cfg_data[0];
				drf_pkg::REG_REC_CRC_EN:  rec_crc_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	drf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.cmd        (s_tuser[0]),
		.data_byte  (s_tdata),
		.last       (s_tlast),
		.is_retry   (s_tuser[1]),
		.rec_crc_en (rec_crc_en_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	drf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (push_job),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (head_job)
	);

	drf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (q_valid),
		.job         (head_job),
		.pop         (q_pop),
		.start_code  (start_code_q),
		.end_code    (end_code_q),
		.append_crlf (append_crlf_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (out_byte),
		.run_last    (m_tlast),
		.frame_end   (m_tuser[0]),
		.rec_check   (rec_check)
	);

	assign m_tdata = {rec_check, out_byte};

endmodule
